// ----- hw/rtl/knn_pkg.sv -----
// Shared constants, codes and helpers of the k-nearest-neighbor classifier.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package knn_pkg;

    localparam int DEF_MAX_RECORDS    = 1024;
    localparam int DEF_FEATURE_COUNT  = 11;
    localparam int DEF_MAX_NEIGHBOURS = 16;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 4;
    localparam int FEAT_W  = 24;
    localparam int LAB_W   = 4;
    localparam int K_CFG_W = 5;
    localparam int DIST_W  = 48;

    localparam logic [OP_W-1:0] OP_TRAIN = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [FEAT_W-1:0] POS_CAP  = 24'h7FFFFF;
    localparam logic [FEAT_W-1:0] NEG_CAP  = 24'h800000;
    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

    typedef struct packed {
        logic back_busy;
        logic queue_empty;
    } knn_hold_t;

    function automatic logic ranks_before(
        input logic [DIST_W-1:0] da,
        input logic [LAB_W-1:0]  la,
        input logic [DIST_W-1:0] db,
        input logic [LAB_W-1:0]  lb
    );
        return (da < db) || ((da == db) && (la < lb));
    endfunction

endpackage

// ----- hw/rtl/knn_majority_classifier.sv -----
// Top level of the k-nearest-neighbor majority classifier: front, command
// queue, record store and back. Depends on knn_pkg and all knn_* modules.
//
//   channel   signals                                          direction
//   input     in_valid, in_stall, operation, feature_index,
//             feature_value, label                             in (stall out)
//   output    out_valid, out_stall, prediction, neighbours_used out (stall in)
//   config    cfg_write, cfg_data                              in
//
// A training or query feature is taken whenever the input does not stall; a
// record end adds a maxima sweep over the store's single read port.
// A query end scans every stored record with the one bit-serial divider of
// 24 steps, which a feature skips if its maximum is zero or it saturates.
// Reset clears the record count, feature maxima and neighbour count (to 1).
// Input stalls while a query or sweep is in progress; a waiting result holds
// the input only while the next query result is ready behind it.
`timescale 1ns / 1ps
module knn_majority_classifier #(
    parameter int MAX_RECORDS    = knn_pkg::DEF_MAX_RECORDS,
    parameter int FEATURE_COUNT  = knn_pkg::DEF_FEATURE_COUNT,
    parameter int MAX_NEIGHBOURS = knn_pkg::DEF_MAX_NEIGHBOURS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [knn_pkg::OP_W-1:0]     operation,
    input  logic [knn_pkg::IDX_W-1:0]    feature_index,
    input  logic [knn_pkg::FEAT_W-1:0]   feature_value,
    input  logic [knn_pkg::LAB_W-1:0]    label,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [knn_pkg::LAB_W-1:0]    prediction,
    output logic [knn_pkg::K_CFG_W-1:0]  neighbours_used,
    input  logic                         cfg_write,
    input  logic [knn_pkg::K_CFG_W-1:0]  cfg_data
);
    import knn_pkg::*;

    localparam int DEPTH = MAX_RECORDS * FEATURE_COUNT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int KW = $clog2(MAX_NEIGHBOURS + 1);
    localparam int IW = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
    localparam int QW = KW + CW;

    knn_hold_t         hold;
    logic              push;
    logic              pop;
    logic              back_busy;
    logic              queue_empty;
    logic [KW-1:0]     cmd_k;
    logic [CW-1:0]     cmd_count;
    logic [QW-1:0]     q_head;
    logic              feat_we;
    logic [AW-1:0]     feat_waddr;
    logic [FEAT_W-1:0] feat_wdata;
    logic              lab_we;
    logic [RW-1:0]     lab_waddr;
    logic [LAB_W-1:0]  lab_wdata;
    logic              sweep_active;
    logic [AW-1:0]     sweep_addr;
    logic [AW-1:0]     back_addr;
    logic [AW-1:0]     feat_raddr;
    logic [RW-1:0]     lab_raddr;
    logic [FEAT_W-1:0] feat_rdata;
    logic [LAB_W-1:0]  lab_rdata;
    logic [FEATURE_COUNT-1:0][FEAT_W-1:0] feature_max;
    logic [FEATURE_COUNT-1:0][FEAT_W-1:0] query;

    assign hold.back_busy   = back_busy;
    assign hold.queue_empty = queue_empty;
    assign feat_raddr       = sweep_active ? sweep_addr : back_addr;

    knn_front #(
        .MAX_RECORDS(MAX_RECORDS), .FEATURE_COUNT(FEATURE_COUNT),
        .MAX_NEIGHBOURS(MAX_NEIGHBOURS), .AW(AW), .RW(RW), .FW(FW), .CW(CW), .KW(KW)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .feature_index(feature_index),
        .feature_value(feature_value), .label(label),
        .cfg_write(cfg_write), .cfg_data(cfg_data), .hold(hold),
        .push(push), .cmd_k(cmd_k), .cmd_count(cmd_count),
        .feat_we(feat_we), .feat_waddr(feat_waddr), .feat_wdata(feat_wdata),
        .lab_we(lab_we), .lab_waddr(lab_waddr), .lab_wdata(lab_wdata),
        .sweep_active(sweep_active), .sweep_addr(sweep_addr),
        .feat_rdata(feat_rdata), .feature_max(feature_max), .query(query)
    );

    knn_queue #(.W(QW)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data({cmd_k, cmd_count}),
        .pop(pop), .head(q_head), .empty(queue_empty)
    );

    knn_store #(.DEPTH(DEPTH), .ROWS(MAX_RECORDS), .AW(AW), .RW(RW)) u_store (
        .clk(clk), .feat_we(feat_we), .feat_waddr(feat_waddr),
        .feat_wdata(feat_wdata), .lab_we(lab_we), .lab_waddr(lab_waddr),
        .lab_wdata(lab_wdata), .feat_raddr(feat_raddr), .lab_raddr(lab_raddr),
        .feat_rdata(feat_rdata), .lab_rdata(lab_rdata)
    );

    knn_back #(
        .MAX_RECORDS(MAX_RECORDS), .FEATURE_COUNT(FEATURE_COUNT),
        .MAX_NEIGHBOURS(MAX_NEIGHBOURS), .AW(AW), .RW(RW), .FW(FW), .CW(CW),
        .KW(KW), .IW(IW)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .queue_empty(queue_empty),
        .cmd_k(q_head[QW-1:CW]), .cmd_count(q_head[CW-1:0]),
        .pop(pop), .busy(back_busy), .feat_raddr(back_addr), .lab_raddr(lab_raddr),
        .feat_rdata(feat_rdata), .lab_rdata(lab_rdata),
        .feature_max(feature_max), .query(query),
        .out_valid(out_valid), .out_stall(out_stall),
        .prediction(prediction), .neighbours_used(neighbours_used)
    );

endmodule

// ----- hw/rtl/knn_store.sv -----
// Training record store: feature memory and label memory, one write and one
// registered read port each. Depends on knn_pkg.
`timescale 1ns / 1ps
module knn_store #(
    parameter int DEPTH = 11264,
    parameter int ROWS  = 1024,
    parameter int AW    = 14,
    parameter int RW    = 10
) (
    input  logic                      clk,
    input  logic                      feat_we,
    input  logic [AW-1:0]             feat_waddr,
    input  logic [knn_pkg::FEAT_W-1:0] feat_wdata,
    input  logic                      lab_we,
    input  logic [RW-1:0]             lab_waddr,
    input  logic [knn_pkg::LAB_W-1:0] lab_wdata,
    input  logic [AW-1:0]             feat_raddr,
    input  logic [RW-1:0]             lab_raddr,
    output logic [knn_pkg::FEAT_W-1:0] feat_rdata,
    output logic [knn_pkg::LAB_W-1:0] lab_rdata
);
    import knn_pkg::*;

    logic [FEAT_W-1:0] feat_mem [DEPTH];
    logic [LAB_W-1:0]  lab_mem [ROWS];
    logic [FEAT_W-1:0] feat_rdata_reg;
    logic [LAB_W-1:0]  lab_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (feat_we)
        begin
            feat_mem[feat_waddr] <= feat_wdata;
        end
        feat_rdata_reg <= feat_mem[feat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lab_we)
        begin
            lab_mem[lab_waddr] <= lab_wdata;
        end
        lab_rdata_reg <= lab_mem[lab_raddr];
    end

    assign feat_rdata = feat_rdata_reg;
    assign lab_rdata  = lab_rdata_reg;

endmodule

// ----- hw/rtl/knn_queue.sv -----
// Two-entry command queue between the front and back parts.
// Depends on knn_pkg.
`timescale 1ns / 1ps
module knn_queue #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         empty
);
    import knn_pkg::*;

    logic [W-1:0] d0_reg;
    logic [W-1:0] d1_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            if (cnt_reg == 2'd0)
            begin
                d0_reg <= push_data;
            end
            else
            begin
                d1_reg <= push_data;
            end
        end
        else if (pop && !push)
        begin
            d0_reg <= d1_reg;
        end
        else if (pop && push)
        begin
            if (cnt_reg == 2'd1)
            begin
                d0_reg <= push_data;
            end
            else
            begin
                d0_reg <= d1_reg;
                d1_reg <= push_data;
            end
        end
    end

    assign head  = d0_reg;
    assign empty = (cnt_reg == 2'd0);

endmodule

// ----- hw/rtl/knn_front.sv -----
// Front part: accepts items, writes training records, tracks feature maxima,
// buffers the query and posts query commands. Depends on knn_pkg.
`timescale 1ns / 1ps
module knn_front #(
    parameter int MAX_RECORDS    = knn_pkg::DEF_MAX_RECORDS,
    parameter int FEATURE_COUNT  = knn_pkg::DEF_FEATURE_COUNT,
    parameter int MAX_NEIGHBOURS = knn_pkg::DEF_MAX_NEIGHBOURS,
    parameter int AW = 14,
    parameter int RW = 10,
    parameter int FW = 4,
    parameter int CW = 11,
    parameter int KW = 5
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  logic [knn_pkg::OP_W-1:0]                      operation,
    input  logic [knn_pkg::IDX_W-1:0]                     feature_index,
    input  logic [knn_pkg::FEAT_W-1:0]                    feature_value,
    input  logic [knn_pkg::LAB_W-1:0]                     label,
    input  logic                                          cfg_write,
    input  logic [knn_pkg::K_CFG_W-1:0]                   cfg_data,
    input  knn_pkg::knn_hold_t                            hold,
    output logic                                          push,
    output logic [KW-1:0]                                 cmd_k,
    output logic [CW-1:0]                                 cmd_count,
    output logic                                          feat_we,
    output logic [AW-1:0]                                 feat_waddr,
    output logic [knn_pkg::FEAT_W-1:0]                    feat_wdata,
    output logic                                          lab_we,
    output logic [RW-1:0]                                 lab_waddr,
    output logic [knn_pkg::LAB_W-1:0]                     lab_wdata,
    output logic                                          sweep_active,
    output logic [AW-1:0]                                 sweep_addr,
    input  logic [knn_pkg::FEAT_W-1:0]                    feat_rdata,
    output logic [FEATURE_COUNT-1:0][knn_pkg::FEAT_W-1:0] feature_max,
    output logic [FEATURE_COUNT-1:0][knn_pkg::FEAT_W-1:0] query
);
    import knn_pkg::*;

    localparam int MW = (CW > KW) ? CW : KW;

    logic [K_CFG_W-1:0] nc_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      base_reg;
    logic [AW-1:0]      sweep_base_reg;
    logic               sweep_reg;
    logic [FW:0]        sweep_cnt_reg;
    logic [FEATURE_COUNT-1:0][FEAT_W-1:0] fmax_reg;
    logic [FEATURE_COUNT-1:0][FEAT_W-1:0] qbuf_reg;

    logic          accept;
    logic          idx_ok;
    logic          last;
    logic          room;
    logic          train_end;
    logic [KW-1:0] k_eff;
    logic [FW-1:0] prev_f;

    assign in_stall = sweep_reg || hold.back_busy || !hold.queue_empty;
    assign accept   = in_valid && !in_stall;
    assign idx_ok   = ({1'b0, feature_index} < (IDX_W + 1)'(FEATURE_COUNT));
    assign last     = (feature_index == IDX_W'(FEATURE_COUNT - 1));
    assign room     = (count_reg < CW'(MAX_RECORDS));

    always_comb
    begin
        if (nc_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (MW'(nc_reg) > MW'(MAX_NEIGHBOURS))
        begin
            k_eff = KW'(MAX_NEIGHBOURS);
        end
        else
        begin
            k_eff = KW'(nc_reg);
        end
    end

    assign feat_we    = accept && (operation == OP_TRAIN) && idx_ok && room;
    assign feat_waddr = base_reg + AW'(feature_index);
    assign feat_wdata = feature_value;
    assign train_end  = feat_we && last;
    assign lab_we     = train_end;
    assign lab_waddr  = count_reg[RW-1:0];
    assign lab_wdata  = label;

    assign push      = accept && (operation == OP_QUERY) && idx_ok && last;
    assign cmd_k     = k_eff;
    assign cmd_count = count_reg;

    assign sweep_active = sweep_reg;
    assign sweep_addr   = sweep_base_reg + AW'(sweep_cnt_reg);
    assign prev_f       = FW'(sweep_cnt_reg - (FW + 1)'(1));

    assign feature_max = fmax_reg;
    assign query       = qbuf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg <= K_CFG_W'(1);
        end
        else if (cfg_write)
        begin
            nc_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            base_reg       <= '0;
            sweep_reg      <= 1'b0;
            sweep_cnt_reg  <= '0;
            sweep_base_reg <= '0;
            fmax_reg       <= '0;
        end
        else
        begin
            if (sweep_reg)
            begin
                if (sweep_cnt_reg != '0)
                begin
                    if (feat_rdata > fmax_reg[prev_f])
                    begin
                        fmax_reg[prev_f] <= feat_rdata;
                    end
                end
                if (sweep_cnt_reg == (FW + 1)'(FEATURE_COUNT))
                begin
                    sweep_reg <= 1'b0;
                end
                sweep_cnt_reg <= sweep_cnt_reg + (FW + 1)'(1);
            end
            if (accept && (operation == OP_CLEAR))
            begin
                count_reg <= '0;
                base_reg  <= '0;
                fmax_reg  <= '0;
            end
            if (train_end)
            begin
                count_reg      <= count_reg + CW'(1);
                base_reg       <= base_reg + AW'(FEATURE_COUNT);
                sweep_base_reg <= base_reg;
                sweep_reg      <= 1'b1;
                sweep_cnt_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (operation == OP_QUERY) && idx_ok)
        begin
            qbuf_reg[feature_index[FW-1:0]] <= feature_value;
        end
    end

endmodule

// ----- hw/rtl/knn_back.sv -----
// Back part: scans the stored records with a shared bit-serial divider, keeps
// the k nearest in a sorted register list and votes. Depends on knn_pkg.
`timescale 1ns / 1ps
module knn_back #(
    parameter int MAX_RECORDS    = knn_pkg::DEF_MAX_RECORDS,
    parameter int FEATURE_COUNT  = knn_pkg::DEF_FEATURE_COUNT,
    parameter int MAX_NEIGHBOURS = knn_pkg::DEF_MAX_NEIGHBOURS,
    parameter int AW = 14,
    parameter int RW = 10,
    parameter int FW = 4,
    parameter int CW = 11,
    parameter int KW = 5,
    parameter int IW = 4
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          queue_empty,
    input  logic [KW-1:0]                                 cmd_k,
    input  logic [CW-1:0]                                 cmd_count,
    output logic                                          pop,
    output logic                                          busy,
    output logic [AW-1:0]                                 feat_raddr,
    output logic [RW-1:0]                                 lab_raddr,
    input  logic [knn_pkg::FEAT_W-1:0]                    feat_rdata,
    input  logic [knn_pkg::LAB_W-1:0]                     lab_rdata,
    input  logic [FEATURE_COUNT-1:0][knn_pkg::FEAT_W-1:0] feature_max,
    input  logic [FEATURE_COUNT-1:0][knn_pkg::FEAT_W-1:0] query,
    output logic                                          out_valid,
    input  logic                                          out_stall,
    output logic [knn_pkg::LAB_W-1:0]                     prediction,
    output logic [knn_pkg::K_CFG_W-1:0]                   neighbours_used
);
    import knn_pkg::*;

    localparam int MW = (CW > KW) ? CW : KW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_LOAD = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_SQ   = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_INS  = 4'd6;
    localparam logic [3:0] S_VOTE = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]        state_reg;
    logic [KW-1:0]     k_reg;
    logic [CW-1:0]     count_reg;
    logic [KW-1:0]     used_reg;
    logic [CW-1:0]     rec_reg;
    logic [FW-1:0]     f_reg;
    logic [AW-1:0]     addr_reg;
    logic [DIST_W-1:0] sum_reg;
    logic [KW-1:0]     filled_reg;
    logic              neg_reg;
    logic [FEAT_W-1:0] m_reg;
    logic [FEAT_W-1:0] rem_reg;
    logic [FEAT_W-1:0] lo_reg;
    logic [FEAT_W-1:0] quo_reg;
    logic [4:0]        bit_reg;
    logic [DIST_W-1:0] sq_reg;
    logic [KW-1:0]     vi_reg;
    logic [KW-1:0]     max_reg;
    logic [LAB_W-1:0]  win_reg;
    logic              out_valid_reg;
    logic [LAB_W-1:0]  pred_reg;
    logic [K_CFG_W-1:0] used_out_reg;
    logic [DIST_W-1:0] best_d_reg [MAX_NEIGHBOURS];
    logic [LAB_W-1:0]  best_l_reg [MAX_NEIGHBOURS];

    logic [FEAT_W-1:0] q_val;
    logic [FEAT_W-1:0] t_val;
    logic [FEAT_W-1:0] m_val;
    logic [FEAT_W-1:0] mag;
    logic              q_ge;
    logic [FEAT_W:0]   trial;
    logic [FEAT_W-1:0] cap;
    logic [FEAT_W-1:0] quo_sat;
    logic [DIST_W:0]   acc_sum;
    logic [MAX_NEIGHBOURS-1:0] lt;
    logic              skip;
    logic [IW-1:0]     k_last;
    logic [LAB_W-1:0]  vote_lab;
    logic [KW-1:0]     vote_cnt;
    logic              out_free;
    logic [KW-1:0]     used_new;

    assign q_val = query[f_reg];
    assign t_val = feat_rdata;
    assign m_val = feature_max[f_reg];
    assign q_ge  = (q_val >= t_val);
    assign mag   = q_ge ? (q_val - t_val) : (t_val - q_val);
    assign trial = {rem_reg, lo_reg[FEAT_W-1]};
    assign cap   = neg_reg ? NEG_CAP : POS_CAP;
    assign quo_sat = (quo_reg > cap) ? cap : quo_reg;
    assign acc_sum = {1'b0, sum_reg} + {1'b0, sq_reg};
    assign k_last  = IW'(k_reg - KW'(1));
    assign out_free = !out_valid_reg || !out_stall;
    assign used_new = (MW'(cmd_count) < MW'(cmd_k)) ? KW'(cmd_count) : cmd_k;

    always_comb
    begin
        for (int j = 0; j < MAX_NEIGHBOURS; j++)
        begin
            lt[j] = (KW'(j) >= filled_reg)
                || ranks_before(sum_reg, lab_rdata, best_d_reg[j], best_l_reg[j]);
        end
        skip = (filled_reg == k_reg) && !lt[k_last];
    end

    always_comb
    begin
        vote_lab = best_l_reg[IW'(vi_reg)];
        vote_cnt = '0;
        for (int j = 0; j < MAX_NEIGHBOURS; j++)
        begin
            if ((KW'(j) < used_reg) && (best_l_reg[j] == vote_lab))
            begin
                vote_cnt = vote_cnt + KW'(1);
            end
        end
    end

    assign pop        = (state_reg == S_IDLE) && !queue_empty;
    assign busy       = (state_reg != S_IDLE);
    assign feat_raddr = addr_reg;
    assign lab_raddr  = rec_reg[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        state_reg <= (cmd_count == '0) ? S_VOTE : S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    if (m_val == '0)
                    begin
                        state_reg <= S_ACC;
                    end
                    else if ({8'd0, mag} >= {m_val, 8'd0})
                    begin
                        state_reg <= S_SQ;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (bit_reg == 5'(FEAT_W - 1))
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= (f_reg == FW'(FEATURE_COUNT - 1)) ? S_INS : S_READ;
                end
                S_INS:
                begin
                    state_reg <= (rec_reg + CW'(1) == count_reg) ? S_VOTE : S_READ;
                end
                S_VOTE:
                begin
                    if (vi_reg >= used_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                k_reg      <= cmd_k;
                count_reg  <= cmd_count;
                used_reg   <= used_new;
                rec_reg    <= '0;
                f_reg      <= '0;
                addr_reg   <= '0;
                sum_reg    <= '0;
                filled_reg <= '0;
                vi_reg     <= '0;
                max_reg    <= '0;
                win_reg    <= '0;
            end
            S_LOAD:
            begin
                neg_reg <= !q_ge;
                m_reg   <= m_val;
                sq_reg  <= '0;
                rem_reg <= {8'd0, mag[FEAT_W-1:8]};
                lo_reg  <= {mag[7:0], 16'd0};
                bit_reg <= '0;
                quo_reg <= q_ge ? POS_CAP : NEG_CAP;
            end
            S_DIV:
            begin
                if (trial >= {1'b0, m_reg})
                begin
                    rem_reg <= FEAT_W'(trial - {1'b0, m_reg});
                    quo_reg <= {quo_reg[FEAT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[FEAT_W-1:0];
                    quo_reg <= {quo_reg[FEAT_W-2:0], 1'b0};
                end
                lo_reg  <= {lo_reg[FEAT_W-2:0], 1'b0};
                bit_reg <= bit_reg + 5'd1;
            end
            S_SQ:
            begin
                sq_reg <= DIST_W'(quo_sat) * DIST_W'(quo_sat);
            end
            S_ACC:
            begin
                sum_reg  <= acc_sum[DIST_W] ? DIST_SAT : acc_sum[DIST_W-1:0];
                addr_reg <= addr_reg + AW'(1);
                f_reg    <= (f_reg == FW'(FEATURE_COUNT - 1)) ? '0 : f_reg + FW'(1);
            end
            S_INS:
            begin
                if (!skip)
                begin
                    for (int j = 0; j < MAX_NEIGHBOURS; j++)
                    begin
                        if ((KW'(j) < k_reg) && lt[j])
                        begin
                            if ((j == 0) || !lt[(j == 0) ? 0 : j - 1])
                            begin
                                best_d_reg[j] <= sum_reg;
                                best_l_reg[j] <= lab_rdata;
                            end
                            else
                            begin
                                best_d_reg[j] <= best_d_reg[(j == 0) ? 0 : j - 1];
                                best_l_reg[j] <= best_l_reg[(j == 0) ? 0 : j - 1];
                            end
                        end
                    end
                    if (filled_reg != k_reg)
                    begin
                        filled_reg <= filled_reg + KW'(1);
                    end
                end
                sum_reg <= '0;
                rec_reg <= rec_reg + CW'(1);
            end
            S_VOTE:
            begin
                if (vi_reg < used_reg)
                begin
                    if (vote_cnt > max_reg)
                    begin
                        max_reg <= vote_cnt;
                        win_reg <= vote_lab;
                    end
                    vi_reg <= vi_reg + KW'(1);
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    pred_reg     <= win_reg;
                    used_out_reg <= K_CFG_W'(used_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign prediction      = pred_reg;
    assign neighbours_used = used_out_reg;

endmodule

// ----- dv/knn_majority_classifier_test.sv -----
// Self-checking testbench of knn_majority_classifier: random and directed items
// are checked against a predictor of the classifier kept in this file.
// Depends on knn_pkg and the knn_majority_classifier RTL.
`timescale 1ns / 1ps
module knn_majority_classifier_test;
    import knn_pkg::*;

    localparam int NREC  = DEF_MAX_RECORDS;
    localparam int NFEAT = DEF_FEATURE_COUNT;
    localparam int NBEST = DEF_MAX_NEIGHBOURS;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [FEAT_W-1:0] val;
        logic [LAB_W-1:0]  lab;
        bit                hold;
    } knn_item_t;

    typedef struct {
        logic [LAB_W-1:0]   pred;
        logic [K_CFG_W-1:0] used;
    } vote_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     operation = '0;
    logic [IDX_W-1:0]    feature_index = '0;
    logic [FEAT_W-1:0]   feature_value = '0;
    logic [LAB_W-1:0]    label = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [LAB_W-1:0]    prediction;
    logic [K_CFG_W-1:0]  neighbours_used;
    logic                cfg_write = 1'b0;
    logic [K_CFG_W-1:0]  cfg_data = '0;

    knn_majority_classifier dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .feature_index(feature_index),
        .feature_value(feature_value), .label(label),
        .out_valid(out_valid), .out_stall(out_stall),
        .prediction(prediction), .neighbours_used(neighbours_used),
        .cfg_write(cfg_write), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    knn_item_t pending_items[$];
    vote_t     expected_votes[$];
    knn_item_t on_wire;
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    // classifier state mirror
    logic [FEAT_W-1:0]  train_feat [0:NREC*NFEAT-1];
    logic [LAB_W-1:0]   train_lab  [0:NREC-1];
    logic [FEAT_W-1:0]  feat_max   [0:NFEAT-1];
    logic [FEAT_W-1:0]  query_feat [0:NFEAT-1];
    int                 stored = 0;
    logic [K_CFG_W-1:0] k_reg = 5'd1;

    function automatic bit ordered_ahead(logic [DIST_W-1:0] da, logic [LAB_W-1:0] la,
                                         logic [DIST_W-1:0] db, logic [LAB_W-1:0] lb);
        return (da < db) || (da == db && la < lb);
    endfunction

    function automatic logic [63:0] feature_term(logic [FEAT_W-1:0] q, logic [FEAT_W-1:0] t,
                                                 logic [FEAT_W-1:0] m);
        logic [63:0] mag, quo, cap;
        if (m == 0)
            return 64'd0;
        mag = (q >= t) ? 64'(q - t) : 64'(t - q);
        quo = (mag << 16) / 64'(m);
        cap = (q >= t) ? 64'h7FFFFF : 64'h800000;
        if (quo > cap)
            quo = cap;
        return quo * quo;
    endfunction

    function automatic logic [DIST_W-1:0] record_distance(int r);
        logic [63:0] sum;
        sum = 0;
        for (int f = 0; f < NFEAT; f++)
        begin
            sum = sum + feature_term(query_feat[f], train_feat[r*NFEAT+f], feat_max[f]);
            if (sum > 64'hFFFF_FFFF_FFFF)
                sum = 64'hFFFF_FFFF_FFFF;
        end
        return sum[DIST_W-1:0];
    endfunction

    function automatic vote_t classify_query();
        logic [DIST_W-1:0] bd [0:NBEST-1];
        logic [LAB_W-1:0]  bl [0:NBEST-1];
        logic [DIST_W-1:0] d;
        logic [LAB_W-1:0]  lb;
        int k, used, filled, i, cnt, maxv;
        vote_t v;
        k = k_reg;
        if (k == 0)
            k = 1;
        if (k > NBEST)
            k = NBEST;
        used = (stored < k) ? stored : k;
        filled = 0;
        maxv = 0;
        v.pred = '0;
        for (int r = 0; r < stored; r++)
        begin
            d = record_distance(r);
            lb = train_lab[r];
            if (filled == k && !ordered_ahead(d, lb, bd[k-1], bl[k-1]))
                continue;
            i = (filled < k) ? filled : k - 1;
            while (i > 0 && ordered_ahead(d, lb, bd[i-1], bl[i-1]))
            begin
                bd[i] = bd[i-1];
                bl[i] = bl[i-1];
                i--;
            end
            bd[i] = d;
            bl[i] = lb;
            if (filled < k)
                filled++;
        end
        for (int a = 0; a < used; a++)
        begin
            cnt = 0;
            for (int b = 0; b < used; b++)
                if (bl[b] == bl[a])
                    cnt++;
            if (cnt > maxv)
            begin
                maxv = cnt;
                v.pred = bl[a];
            end
        end
        v.used = used[K_CFG_W-1:0];
        return v;
    endfunction

    task automatic apply_item(knn_item_t it);
        int base;
        if (it.op == OP_CLEAR)
        begin
            stored = 0;
            for (int f = 0; f < NFEAT; f++)
                feat_max[f] = '0;
        end
        else if (it.idx < NFEAT)
        begin
            if (it.op == OP_TRAIN && stored < NREC)
            begin
                base = stored * NFEAT;
                train_feat[base + it.idx] = it.val;
                if (it.idx == NFEAT - 1)
                begin
                    train_lab[stored] = it.lab;
                    for (int f = 0; f < NFEAT; f++)
                        if (train_feat[base+f] > feat_max[f])
                            feat_max[f] = train_feat[base+f];
                    stored++;
                end
            end
            else if (it.op == OP_QUERY)
            begin
                query_feat[it.idx] = it.val;
                if (it.idx == NFEAT - 1)
                    expected_votes = {expected_votes, classify_query()};
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_item(on_wire);
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct &&
                    (!pending_items[0].hold || expected_votes.size() == 0))
                begin
                    on_wire = pending_items.pop_front();
                    in_valid <= 1'b1;
                    operation <= on_wire.op;
                    feature_index <= on_wire.idx;
                    feature_value <= on_wire.val;
                    label <= on_wire.lab;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        vote_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_votes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result prediction=%0d neighbours_used=%0d",
                             $realtime, prediction, neighbours_used);
                end
                else
                begin
                    e = expected_votes.pop_front();
                    if (prediction !== e.pred)
                    begin
                        errors++;
                        $display("%0t: prediction expected %0d actual %0d",
                                 $realtime, e.pred, prediction);
                    end
                    if (neighbours_used !== e.used)
                    begin
                        errors++;
                        $display("%0t: neighbours_used expected %0d actual %0d",
                                 $realtime, e.used, neighbours_used);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // stimulus mirror of the record store, so that no unwritten slot is read
    int gen_rc = 0;
    bit row_done [0:NREC-1];
    bit query_done = 1'b0;
    int zero_feat = NFEAT;
    int gen_queries = 0;
    int gen_items = 0;

    task automatic push_item(logic [OP_W-1:0] op, int idx, logic [FEAT_W-1:0] val,
                             logic [LAB_W-1:0] lab, bit hold);
        knn_item_t it;
        it.op = op;
        it.idx = idx[IDX_W-1:0];
        it.val = val;
        it.lab = lab;
        it.hold = hold;
        pending_items = {pending_items, it};
        gen_items++;
    endtask

    // f below zero asks for a value of any feature
    function automatic logic [FEAT_W-1:0] pick_value(int f);
        int r;
        if (f == zero_feat)
            return '0;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return 24'hFFFFFF;
            2, 3: return 24'($urandom_range(0, 255));
            4, 5: return 24'(($urandom_range(0, 3)) << 20);
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [LAB_W-1:0] pick_label();
        if ($urandom_range(0, 1))
            return LAB_W'($urandom_range(0, 3));
        return LAB_W'($urandom_range(0, 15));
    endfunction

    task automatic gen_record(bit broken, bit hold);
        int n;
        if (broken && gen_rc < NREC && row_done[gen_rc])
        begin
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                push_item(OP_TRAIN, $urandom_range(0, NFEAT - 2), pick_value(-1), '0,
                          hold && i == 0);
        end
        else
        begin
            for (int f = 0; f < NFEAT - 1; f++)
                push_item(OP_TRAIN, f, pick_value(f), LAB_W'($urandom_range(0, 15)),
                          hold && f == 0);
            if ($urandom_range(0, 4) == 0)
                push_item(OP_TRAIN, $urandom_range(0, NFEAT - 2), pick_value(-1), '0, 1'b0);
        end
        push_item(OP_TRAIN, NFEAT - 1, pick_value(NFEAT - 1), pick_label(), 1'b0);
        if (gen_rc < NREC)
        begin
            row_done[gen_rc] = 1'b1;
            gen_rc++;
        end
    endtask

    task automatic gen_query(bit broken, bit hold);
        int n;
        if (broken && query_done)
        begin
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                push_item(OP_QUERY, $urandom_range(0, NFEAT - 2), pick_value(-1),
                          LAB_W'($urandom_range(0, 15)), hold && i == 0);
        end
        else
        begin
            for (int f = 0; f < NFEAT - 1; f++)
                push_item(OP_QUERY, f, pick_value(-1), LAB_W'($urandom_range(0, 15)),
                          hold && f == 0);
        end
        push_item(OP_QUERY, NFEAT - 1, pick_value(-1), LAB_W'($urandom_range(0, 15)), 1'b0);
        query_done = 1'b1;
        gen_queries++;
    endtask

    task automatic gen_clear(bit hold);
        push_item(OP_CLEAR, $urandom_range(0, 15), 24'($urandom()),
                  LAB_W'($urandom_range(0, 15)), hold);
        gen_rc = 0;
        zero_feat = $urandom_range(0, NFEAT);
    endtask

    task automatic gen_noise();
        if ($urandom_range(0, 1))
            push_item(OP_UNUSED, $urandom_range(0, 15), 24'($urandom()),
                      LAB_W'($urandom_range(0, 15)), 1'b0);
        else
            push_item($urandom_range(0, 1) ? OP_QUERY : OP_TRAIN, $urandom_range(NFEAT, 15),
                      24'($urandom()), LAB_W'($urandom_range(0, 15)), 1'b0);
        gen_items--;
    endtask

    task automatic write_k(logic [K_CFG_W-1:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        k_reg = v;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (!(pending_items.size() == 0 && !in_valid && expected_votes.size() == 0));
        repeat (64) @(posedge clk);
    endtask

    task automatic random_phase(int n_items, int min_queries);
        int r, stop;
        bit hold;
        stop = gen_items + n_items;
        while (gen_items < stop || gen_queries < min_queries)
        begin
            r = $urandom_range(0, 99);
            hold = ($urandom_range(0, 99) < 6);
            if (r < 45)
                gen_record(1'b0, hold);
            else if (r < 52)
                gen_record(1'b1, hold);
            else if (r < 80)
                gen_query(1'b0, hold);
            else if (r < 85)
                gen_query(1'b1, hold);
            else if (r < 91)
                gen_clear(hold);
            else
                gen_noise();
        end
    endtask

    initial
    begin
        logic [K_CFG_W-1:0] ks [0:5];
        ks = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd0};
        ks[5] = K_CFG_W'($urandom_range(0, 31));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 47;
        write_k(5'd3);
        gen_query(1'b0, 1'b0);
        gen_noise();
        push_item(OP_UNUSED, NFEAT - 1, 24'hFFFFFF, 4'hF, 1'b0);
        gen_clear(1'b0);
        for (int f = 0; f < NFEAT - 1; f++)
            push_item(OP_TRAIN, f, 24'hFFFFFF, 4'hF, 1'b0);
        push_item(OP_TRAIN, NFEAT - 1, 24'hFFFFFF, 4'hF, 1'b0);
        gen_rc = 1;
        row_done[0] = 1'b1;
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 2)
            begin
                send_idle_pct = 34;
                recv_idle_pct = 47;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 34;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_k(ks[ph]);
            random_phase(88, 0);
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
